/* hw/rtl/vqme_pkg.sv */
// Shared types and constants for the voxel quad mesh emitter.
`timescale 1ns / 1ps

package vqme_pkg;

    // Configuration register file
    localparam int CFG_SIZE_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FACE_MODE = 2'd3;
    localparam logic [CFG_SIZE_W-1:0] SIZE_RESET   = 9'd16;

    // Field widths
    localparam int WORD_W  = 32;
    localparam int COORD_W = 10;
    localparam int COLOR_W = 8;
    localparam int NUM_FACES = 6;
    localparam int FACE_W  = 3;
    localparam int CORNER_W = 2;
    localparam logic [CORNER_W-1:0] LAST_CORNER = 2'd3;

    // Queue between front and back
    localparam int QDEPTH = 2;

    // Top byte bit that enables each face, in emission order
    localparam int FACE_BIT_POS [0:NUM_FACES-1] = '{5, 6, 4, 3, 2, 1};

    // Corner code per face and corner: bit0 = +x, bit1 = +y, bit2 = +z.
    // Indexed by {face, corner}.
    typedef logic [2:0] corner_t;
    localparam corner_t CORNER_TAB [0:23] = '{
        3'd0, 3'd1, 3'd3, 3'd2,
        3'd4, 3'd5, 3'd7, 3'd6,
        3'd0, 3'd1, 3'd5, 3'd4,
        3'd2, 3'd3, 3'd7, 3'd6,
        3'd0, 3'd2, 3'd6, 3'd4,
        3'd1, 3'd3, 3'd7, 3'd5
    };

    typedef struct packed {
        logic [CFG_SIZE_W-1:0] size_x;
        logic [CFG_SIZE_W-1:0] size_y;
        logic [CFG_SIZE_W-1:0] size_z;
        logic                  face_mask_mode;
    } cfg_t;

    // One present voxel handed from front to back
    typedef struct packed {
        logic [COORD_W-1:0]   base_x;
        logic [COORD_W-1:0]   base_y;
        logic [COORD_W-1:0]   base_z;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
        logic [NUM_FACES-1:0] faces;
    } entry_t;

endpackage

/* hw/rtl/vqme_front.sv */
// Front end: position counters, face classification and base coordinates.
`timescale 1ns / 1ps

module vqme_front import vqme_pkg::*; #(
    parameter int MAX_EDGE = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [WORD_W-1:0] voxel_word,
    output logic              push_valid,
    input  logic              push_ready,
    output entry_t            push_entry
);

    localparam int CNT_W = $clog2(MAX_EDGE);
    localparam int EFF_W = CNT_W + 1;

    // Size 0 acts as 1, sizes above the edge limit are clamped
    function automatic logic [EFF_W-1:0] eff_size(input logic [CFG_SIZE_W-1:0] s);
        logic [EFF_W-1:0] e;
        if (s == '0)
            e = EFF_W'(1);
        else if (32'(s) > 32'(MAX_EDGE))
            e = EFF_W'(MAX_EDGE);
        else
            e = EFF_W'(s);
        return e;
    endfunction

    logic [CNT_W-1:0] cnt_x_reg, cnt_y_reg, cnt_z_reg;
    logic [CNT_W-1:0] cnt_x_next, cnt_y_next, cnt_z_next;
    logic [EFF_W-1:0] eff_x, eff_y, eff_z;
    logic [EFF_W-1:0] inc_x, inc_y, inc_z;
    logic             wrap_x, wrap_y, wrap_z;
    logic             accept;
    logic [7:0]       top;
    logic [NUM_FACES-1:0] faces;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign top      = voxel_word[31:24];

    assign eff_x = eff_size(cfg.size_x);
    assign eff_y = eff_size(cfg.size_y);
    assign eff_z = eff_size(cfg.size_z);

    // Face selection; a zero top byte is always empty
    always_comb
    begin
        for (int f = 0; f < NUM_FACES; f++)
        begin
            if (cfg.face_mask_mode)
                faces[f] = top[FACE_BIT_POS[f]];
            else
                faces[f] = (top != 8'd0);
        end
    end

    // Centered base coordinates of the current voxel
    always_comb
    begin
        push_entry.base_x = COORD_W'(cnt_x_reg) - COORD_W'(eff_x >> 1);
        push_entry.base_y = COORD_W'(cnt_y_reg) - COORD_W'(eff_y >> 1);
        push_entry.base_z = COORD_W'(cnt_z_reg) - COORD_W'(eff_z >> 1);
        push_entry.red    = voxel_word[7:0];
        push_entry.green  = voxel_word[15:8];
        push_entry.blue   = voxel_word[23:16];
        push_entry.faces  = faces;
    end

    assign push_valid = in_valid && (faces != '0);

    // Counter advance, x fastest
    always_comb
    begin
        inc_x  = {1'b0, cnt_x_reg} + EFF_W'(1);
        inc_y  = {1'b0, cnt_y_reg} + EFF_W'(1);
        inc_z  = {1'b0, cnt_z_reg} + EFF_W'(1);
        wrap_x = (inc_x >= eff_x);
        wrap_y = (inc_y >= eff_y);
        wrap_z = (inc_z >= eff_z);
        cnt_x_next = cnt_x_reg;
        cnt_y_next = cnt_y_reg;
        cnt_z_next = cnt_z_reg;
        if (accept)
        begin
            cnt_x_next = wrap_x ? '0 : inc_x[CNT_W-1:0];
            if (wrap_x)
            begin
                cnt_y_next = wrap_y ? '0 : inc_y[CNT_W-1:0];
                if (wrap_y)
                    cnt_z_next = wrap_z ? '0 : inc_z[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_x_reg <= '0;
            cnt_y_reg <= '0;
            cnt_z_reg <= '0;
        end
        else
        begin
            cnt_x_reg <= cnt_x_next;
            cnt_y_reg <= cnt_y_next;
            cnt_z_reg <= cnt_z_next;
        end
    end

    // Only voxels with a nonzero top byte reach the queue
    a_push_present: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> top != 8'd0)
        else $error("empty voxel pushed to queue");

endmodule

/* hw/rtl/vqme_queue.sv */
// Short queue of classified voxels between front and back.
`timescale 1ns / 1ps

module vqme_queue import vqme_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_entry,
    output logic   pop_valid,
    input  logic   pop_ready,
    output entry_t pop_entry
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    entry_t           mem [0:QDEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QDEPTH))
        else $error("queue fill count beyond depth");

endmodule

/* hw/rtl/vqme_back.sv */
// Back end: walks faces and corners of one voxel, one vertex per cycle unless the output stalls.
`timescale 1ns / 1ps

module vqme_back import vqme_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  entry_t                    pop_entry,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] vert_x,
    output logic signed [COORD_W-1:0] vert_y,
    output logic signed [COORD_W-1:0] vert_z,
    output logic [COLOR_W-1:0]        red,
    output logic [COLOR_W-1:0]        green,
    output logic [COLOR_W-1:0]        blue,
    output logic                      last_vertex
);

    entry_t               ent_reg;
    logic                 busy_reg;
    logic [NUM_FACES-1:0] faces_reg;
    logic [CORNER_W-1:0]  corner_reg;

    logic                 out_valid_reg;
    logic [COORD_W-1:0]   vx_reg, vy_reg, vz_reg;
    logic [COLOR_W-1:0]   r_reg, g_reg, b_reg;
    logic                 last_reg;

    logic [FACE_W-1:0]    face_idx;
    logic [NUM_FACES-1:0] faces_left;
    logic                 last_face;
    logic                 advance, emit, fin;
    corner_t              cc;

    // Lowest pending face in emission order
    always_comb
    begin
        face_idx = '0;
        for (int f = NUM_FACES - 1; f >= 0; f--)
        begin
            if (faces_reg[f])
                face_idx = FACE_W'(f);
        end
        faces_left = faces_reg & ~(NUM_FACES'(1) << face_idx);
        last_face  = (faces_left == '0);
    end

    assign cc        = CORNER_TAB[{face_idx, corner_reg}];
    assign advance   = !out_valid_reg || out_ready;
    assign emit      = busy_reg && advance;
    assign fin       = emit && (corner_reg == LAST_CORNER) && last_face;
    assign pop_ready = !busy_reg || fin;

    // Walker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            faces_reg  <= '0;
            corner_reg <= '0;
        end
        else if (pop_valid && pop_ready)
        begin
            busy_reg   <= 1'b1;
            faces_reg  <= pop_entry.faces;
            corner_reg <= '0;
        end
        else if (emit)
        begin
            corner_reg <= corner_reg + CORNER_W'(1);
            if (corner_reg == LAST_CORNER)
                faces_reg <= faces_left;
            if (fin)
                busy_reg <= 1'b0;
        end
    end

    // Voxel payload held while walking
    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
            ent_reg <= pop_entry;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            vx_reg   <= ent_reg.base_x + COORD_W'(cc[0]);
            vy_reg   <= ent_reg.base_y + COORD_W'(cc[1]);
            vz_reg   <= ent_reg.base_z + COORD_W'(cc[2]);
            r_reg    <= ent_reg.red;
            g_reg    <= ent_reg.green;
            b_reg    <= ent_reg.blue;
            last_reg <= (corner_reg == LAST_CORNER) && last_face;
        end
    end

    assign out_valid   = out_valid_reg;
    assign vert_x      = $signed(vx_reg);
    assign vert_y      = $signed(vy_reg);
    assign vert_z      = $signed(vz_reg);
    assign red         = r_reg;
    assign green       = g_reg;
    assign blue        = b_reg;
    assign last_vertex = last_reg;

    a_busy_has_faces: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> faces_reg != '0)
        else $error("walker busy with no faces left");

    a_corner_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> corner_reg == '0)
        else $error("corner count moved while idle");

    a_fin_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> out_valid_reg && last_reg)
        else $error("final vertex not marked last");

endmodule

/* hw/rtl/voxel_quad_mesh_emitter_unit.sv */
// Top level of the voxel quad mesh emitter: config registers, front, queue, back.
//
//  channel  dir  handshake              payload
//  in       in   in_valid / in_ready    voxel_word
//  out      out  out_valid / out_ready  vert_x, vert_y, vert_z, red, green, blue, last_vertex
//  cfg      in   cfg_we                 cfg_index, cfg_data
//
// A present voxel gives 4 vertices per visible face at the back walker, 24 for a full
// cube; the walker emits one vertex per cycle unless out_ready stalls it, and moves to the
// next voxel without a gap. An empty voxel is taken at the front and never reaches the back.
// A 2-entry queue lets the front keep taking words while the back drains a voxel;
// a full queue holds off every word, empty ones included.
// Reset: sizes 16, unmasked mode, position counters 0, queue and output empty.
`timescale 1ns / 1ps

module voxel_quad_mesh_emitter_unit import vqme_pkg::*; #(
    parameter int MAX_EDGE = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_SIZE_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [WORD_W-1:0]         voxel_word,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] vert_x,
    output logic signed [COORD_W-1:0] vert_y,
    output logic signed [COORD_W-1:0] vert_z,
    output logic [COLOR_W-1:0]        red,
    output logic [COLOR_W-1:0]        green,
    output logic [COLOR_W-1:0]        blue,
    output logic                      last_vertex
);

    cfg_t   cfg_reg;
    logic   push_valid, push_ready;
    entry_t push_entry;
    logic   pop_valid, pop_ready;
    entry_t pop_entry;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_x         <= SIZE_RESET;
            cfg_reg.size_y         <= SIZE_RESET;
            cfg_reg.size_z         <= SIZE_RESET;
            cfg_reg.face_mask_mode <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIZE_X:    cfg_reg.size_x         <= cfg_data;
                REG_SIZE_Y:    cfg_reg.size_y         <= cfg_data;
                REG_SIZE_Z:    cfg_reg.size_z         <= cfg_data;
                REG_FACE_MODE: cfg_reg.face_mask_mode <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    vqme_front #(
        .MAX_EDGE (MAX_EDGE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .voxel_word (voxel_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    vqme_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    vqme_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_entry   (pop_entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .vert_z      (vert_z),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_vertex (last_vertex)
    );

endmodule
